FILE: design/mbrx_pkg.sv
package mbrx_pkg;

  localparam int FRAME_BYTES    = 8;
  localparam int OVERFLOW_LIMIT = 64;
  localparam int CRC_SPAN       = 6;

  localparam int FILL_W = 6;
  localparam int WIN_IDX_W = $clog2(FRAME_BYTES);

  localparam logic [7:0]  FUNC_READ    = 8'd3;
  localparam logic [7:0]  OWN_ADDR_RST = 8'd1;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  localparam logic [2:0] ST_PENDING  = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_CRCFAIL  = 3'd2;
  localparam logic [2:0] ST_OTHER    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // Fold one byte into the reflected Modbus CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/modbus_rtu_read_request_receiver_core.sv
// Modbus RTU read-request receiver. Bytes enter on the rx_byte beat channel
// and each one produces exactly one result beat: status pending while a frame
// is still building, request accepted (with start register and register count)
// when an 8-byte function-3 frame carries a good CRC-16 and byte 0 equals
// own_address, CRC fail when the check fails (the oldest byte is dropped and
// the window keeps sliding), other station when the CRC is good but the address
// differs, and overflow after 64 bytes without a frame check. A byte that does
// not complete an armed frame gets its result straight from idle. A byte that
// completes one is stored, the byte-wide CRC unit steps over window bytes 0..5,
// and the verdict is compared and the window updated. Results sit in an output
// register, so the next byte is taken while an earlier result still waits, as
// long as that register is free or being drained. own_address resets to 1; the
// user must write it via cfg_we_i/cfg_wdata_i only while idle (not enforced).
module modbus_rtu_read_request_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] start_register_o,
  output logic [15:0] register_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int WIN_IDX_W = mbrx_pkg::WIN_IDX_W;
  localparam int FILL_W    = mbrx_pkg::FILL_W;

  logic [1:0]  state_q, state_d;
  logic [7:0]  own_addr_q;
  logic [7:0]  win_q [mbrx_pkg::FRAME_BYTES];
  logic [7:0]  win_d [mbrx_pkg::FRAME_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic        armed_q, armed_d;
  logic [15:0] crc_q, crc_d;
  logic [WIN_IDX_W-1:0] crc_idx_q, crc_idx_d;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q, status_d;
  logic [15:0] start_q, start_d;
  logic [15:0] count_q, count_d;

  logic        out_free;
  logic        in_fire;
  logic [FILL_W:0] fill_inc;
  logic [7:0]  win1_new;
  logic        armed_new;
  logic        crc_ok;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign fill_inc  = {1'b0, fill_q} + (FILL_W+1)'(1);
  assign win1_new  = (fill_q == FILL_W'(1)) ? rx_byte_i : win_q[1];
  assign armed_new = armed_q || (win1_new == mbrx_pkg::FUNC_READ);
  assign crc_ok    = (crc_q == {win_q[7], win_q[6]});

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    fill_d      = fill_q;
    armed_d     = armed_q;
    crc_d       = crc_q;
    crc_idx_d   = crc_idx_q;
    status_d    = status_q;
    start_d     = start_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // Store the byte only while the window has room.
          if (fill_q < FILL_W'(mbrx_pkg::FRAME_BYTES)) begin
            win_d[fill_q[WIN_IDX_W-1:0]] = rx_byte_i;
          end
          armed_d = armed_new;
          if (armed_new && fill_inc == (FILL_W+1)'(mbrx_pkg::FRAME_BYTES)) begin
            // Frame complete: run the CRC over bytes 0..5.
            fill_d    = fill_inc[FILL_W-1:0];
            crc_d     = mbrx_pkg::CRC_INIT;
            crc_idx_d = '0;
            state_d   = S_CRC;
          end else begin
            out_valid_d = 1'b1;
            start_d     = '0;
            count_d     = '0;
            if (fill_inc >= (FILL_W+1)'(mbrx_pkg::OVERFLOW_LIMIT)) begin
              // Too many bytes without a check: drop the window, keep arming.
              status_d = mbrx_pkg::ST_OVERFLOW;
              fill_d   = '0;
              for (int i = 0; i < mbrx_pkg::FRAME_BYTES; i++) begin
                win_d[i] = '0;
              end
            end else begin
              status_d = mbrx_pkg::ST_PENDING;
              fill_d   = fill_inc[FILL_W-1:0];
            end
          end
        end
      end
      S_CRC: begin
        crc_d     = mbrx_pkg::crc16_byte(crc_q, win_q[crc_idx_q]);
        crc_idx_d = crc_idx_q + WIN_IDX_W'(1);
        if (crc_idx_q == WIN_IDX_W'(mbrx_pkg::CRC_SPAN - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the verdict until the output register is free.
        if (out_free) begin
          out_valid_d = 1'b1;
          start_d     = '0;
          count_d     = '0;
          state_d     = S_IDLE;
          if (crc_ok) begin
            if (win_q[0] == own_addr_q) begin
              status_d = mbrx_pkg::ST_ACCEPT;
              start_d  = {win_q[2], win_q[3]};
              count_d  = {win_q[4], win_q[5]};
            end else begin
              status_d = mbrx_pkg::ST_OTHER;
            end
            for (int i = 0; i < mbrx_pkg::FRAME_BYTES; i++) begin
              win_d[i] = '0;
            end
            fill_d  = '0;
            armed_d = 1'b0;
          end else begin
            // Slide: drop the oldest byte, the last one keeps its value.
            status_d = mbrx_pkg::ST_CRCFAIL;
            for (int i = 0; i < mbrx_pkg::FRAME_BYTES - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            fill_d = FILL_W'(mbrx_pkg::FRAME_BYTES - 1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      own_addr_q  <= mbrx_pkg::OWN_ADDR_RST;
      fill_q      <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mbrx_pkg::FRAME_BYTES; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      win_q       <= win_d;
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q     <= crc_d;
    crc_idx_q <= crc_idx_d;
    status_q  <= status_d;
    start_q   <= start_d;
    count_q   <= count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign start_register_o = start_q;
  assign register_count_o = count_q;

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  a_crc_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CRC |-> crc_idx_q < WIN_IDX_W'(mbrx_pkg::CRC_SPAN))
    else $error("CRC index past span");

  a_done_after_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC && crc_idx_q == WIN_IDX_W'(mbrx_pkg::CRC_SPAN - 1))
      |=> state_q == S_DONE)
    else $error("CRC sequence did not finish");

  a_armed_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> fill_q <= FILL_W'(mbrx_pkg::FRAME_BYTES))
    else $error("armed with fill past frame");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_q <= mbrx_pkg::ST_OVERFLOW)
    else $error("bad status code");
`endif

endmodule
